// File: rtl/pirc_pkg.sv
`default_nettype none

package pirc_pkg;

    // integrator width and the shared multiplier geometry
    localparam int INTEG_W   = 48;
    localparam int TARGET_W  = 16;
    localparam int ERR_W     = 25;
    localparam int IHI_W     = INTEG_W - 24;
    localparam int MUL_A_W   = (IHI_W > ERR_W) ? IHI_W : ERR_W;
    localparam int MUL_B_W   = 17;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int SUM_W     = MUL_P_W + 2;
    localparam int INT_SUM_W = ((INTEG_W > MUL_P_W) ? INTEG_W : MUL_P_W) + 1;

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    // configuration register indexes
    localparam logic [1:0] CFG_P_GAIN     = 2'd0;
    localparam logic [1:0] CFG_I_GAIN     = 2'd1;
    localparam logic [1:0] CFG_MAX_OUTPUT = 2'd2;
    localparam logic [1:0] CFG_SLOPE      = 2'd3;

    // item function codes
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_RESET  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SP,
        S_ERR,
        S_TK,
        S_INT,
        S_ILO,
        S_IHI,
        S_FINISH
    } t_state;

endpackage

`default_nettype wire

// File: rtl/pi_rate_controller_feedforward_unit.sv
`default_nettype none

// rate pi controller with feed-forward. a control sample transfer forms the
// setpoint (target*slope)>>8, the error against the measured rate, adds
// ticks*error into a saturating integrator and returns
// drive = target + (p_gain*error)>>8 + (i_gain*integrator)>>24, clamped to
// +/-max_output; clamped flags a limited result, and when the clamp acts in
// the direction of the error the integrator keeps its old value. a reset item
// clears the integrator and returns drive 0. one signed multiplier is reused
// five times under a small sequencer (setpoint, ticks, proportional, low and
// high integral products), and a reset item goes straight to the last step;
// the input side is ready only while the sequencer is idle. a finished result
// sits in an output register, so the next item can be taken while it waits;
// the sequencer only holds in its last step if the previous result has not
// been transferred yet.
// configuration is written through a plain write port with no handshake and
// should only be changed while the block is idle.
module pi_rate_controller_feedforward_unit (
    input  wire                logic        i_clk,
    input  wire                logic        i_rst_n,
    // configuration write port
    input  wire                logic        i_cfg_we,
    input  wire                logic [1:0]  i_cfg_idx,
    input  wire                logic [15:0] i_cfg_data,
    // sample input
    input  wire                logic        i_in_valid,
    output                     logic        o_in_ready,
    input  wire                logic        i_in_func,
    input  wire                logic signed [15:0] i_in_target_command,
    input  wire                logic signed [15:0] i_in_measured_rate,
    input  wire                logic [15:0] i_in_elapsed_ticks,
    // result output
    output                     logic        o_out_valid,
    input  wire                logic        i_out_ready,
    output                     logic signed [15:0] o_out_drive,
    output                     logic        o_out_clamped
);

    // configuration registers
    logic [15:0] r_p_gain;
    logic [15:0] r_i_gain;
    logic [14:0] r_max_output;
    logic [15:0] r_slope;

    // sequencer
    pirc_pkg::t_state r_state;
    pirc_pkg::t_state n_state;

    // captured sample
    logic                                    r_func_rst;
    logic signed [pirc_pkg::TARGET_W-1:0]    r_target;
    logic signed [15:0]                      r_rate;
    logic [15:0]                             r_ticks;

    // datapath
    logic signed [pirc_pkg::ERR_W-1:0]       r_err;
    logic signed [pirc_pkg::MUL_P_W-1:0]     r_prod;
    logic signed [pirc_pkg::INTEG_W-1:0]     r_integ;
    logic signed [pirc_pkg::INTEG_W-1:0]     r_integ_new;
    logic signed [pirc_pkg::SUM_W-1:0]       r_acc;

    // output register
    logic               r_out_valid;
    logic signed [15:0] r_drive;
    logic               r_clamped;

    // shared multiplier operands
    logic signed [pirc_pkg::MUL_A_W-1:0]     mul_a;
    logic signed [pirc_pkg::MUL_B_W-1:0]     mul_b;
    logic signed [pirc_pkg::MUL_P_W-1:0]     mul_p;

    logic signed [pirc_pkg::INT_SUM_W-1:0]   integ_sum;
    logic signed [pirc_pkg::INTEG_W-1:0]     integ_sat;
    logic signed [pirc_pkg::SUM_W-1:0]       drive_sum;
    logic signed [pirc_pkg::SUM_W-1:0]       lim_pos;
    logic signed [pirc_pkg::SUM_W-1:0]       lim_neg;
    logic                                    over_hi;
    logic                                    over_lo;
    logic                                    out_free;
    logic                                    in_xfer;

    assign o_in_ready    = (r_state == pirc_pkg::S_IDLE);
    assign in_xfer       = i_in_valid && o_in_ready;
    assign out_free      = !r_out_valid || i_out_ready;
    assign o_out_valid   = r_out_valid;
    assign o_out_drive   = r_drive;
    assign o_out_clamped = r_clamped;

    // configuration writes, a zero slope is stored as one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_gain     <= '0;
            r_i_gain     <= '0;
            r_max_output <= 15'h7fff;
            r_slope      <= 16'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pirc_pkg::CFG_P_GAIN:     r_p_gain     <= i_cfg_data;
                pirc_pkg::CFG_I_GAIN:     r_i_gain     <= i_cfg_data;
                pirc_pkg::CFG_MAX_OUTPUT: r_max_output <= i_cfg_data[14:0];
                pirc_pkg::CFG_SLOPE:      r_slope      <= (i_cfg_data == 16'd0) ? 16'd1
                                                                                : i_cfg_data;
                default: ;
            endcase
        end
    end

    // operand select for the one multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            pirc_pkg::S_SP: begin
                mul_a = pirc_pkg::MUL_A_W'(r_target);
                mul_b = $signed({1'b0, r_slope});
            end
            pirc_pkg::S_TK: begin
                mul_a = pirc_pkg::MUL_A_W'(r_err);
                mul_b = $signed({1'b0, r_ticks});
            end
            pirc_pkg::S_INT: begin
                mul_a = pirc_pkg::MUL_A_W'(r_err);
                mul_b = $signed({1'b0, r_p_gain});
            end
            pirc_pkg::S_ILO: begin
                // low 24 integrator bits, unsigned
                mul_a = $signed({{(pirc_pkg::MUL_A_W-24){1'b0}}, r_integ_new[23:0]});
                mul_b = $signed({1'b0, r_i_gain});
            end
            pirc_pkg::S_IHI: begin
                // integrator floor-shifted by 24
                mul_a = pirc_pkg::MUL_A_W'($signed(r_integ_new[pirc_pkg::INTEG_W-1:24]));
                mul_b = $signed({1'b0, r_i_gain});
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // saturating integrator add of ticks*error
    assign integ_sum = pirc_pkg::INT_SUM_W'(r_integ) + pirc_pkg::INT_SUM_W'(r_prod);

    always_comb begin
        if (integ_sum > pirc_pkg::INT_SUM_W'(pirc_pkg::INTEG_MAX)) begin
            integ_sat = pirc_pkg::INTEG_MAX;
        end else if (integ_sum < pirc_pkg::INT_SUM_W'(pirc_pkg::INTEG_MIN)) begin
            integ_sat = pirc_pkg::INTEG_MIN;
        end else begin
            integ_sat = integ_sum[pirc_pkg::INTEG_W-1:0];
        end
    end

    // final sum with the high integral partial product, then the clamp
    assign drive_sum = r_acc + pirc_pkg::SUM_W'(r_prod);
    assign lim_pos   = $signed({{(pirc_pkg::SUM_W-15){1'b0}}, r_max_output});
    assign lim_neg   = -lim_pos;
    assign over_hi   = drive_sum > lim_pos;
    assign over_lo   = drive_sum < lim_neg;

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pirc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pirc_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_state = (i_in_func == pirc_pkg::FUNC_RESET) ? pirc_pkg::S_FINISH
                                                                  : pirc_pkg::S_SP;
                end
            end
            pirc_pkg::S_SP:     n_state = pirc_pkg::S_ERR;
            pirc_pkg::S_ERR:    n_state = pirc_pkg::S_TK;
            pirc_pkg::S_TK:     n_state = pirc_pkg::S_INT;
            pirc_pkg::S_INT:    n_state = pirc_pkg::S_ILO;
            pirc_pkg::S_ILO:    n_state = pirc_pkg::S_IHI;
            pirc_pkg::S_IHI:    n_state = pirc_pkg::S_FINISH;
            pirc_pkg::S_FINISH: begin
                // hold until the output register can take the result
                if (out_free) begin
                    n_state = pirc_pkg::S_IDLE;
                end
            end
            default: n_state = pirc_pkg::S_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            pirc_pkg::S_IDLE: begin
                if (in_xfer) begin
                    r_func_rst <= (i_in_func == pirc_pkg::FUNC_RESET);
                    r_target   <= i_in_target_command;
                    r_rate     <= i_in_measured_rate;
                    r_ticks    <= i_in_elapsed_ticks;
                end
            end
            pirc_pkg::S_SP: begin
                r_prod <= mul_p;
            end
            pirc_pkg::S_ERR: begin
                // setpoint is the product floor-shifted by 8
                r_err <= pirc_pkg::ERR_W'($signed(r_prod[31:8])) - pirc_pkg::ERR_W'(r_rate);
            end
            pirc_pkg::S_TK: begin
                r_prod <= mul_p;
            end
            pirc_pkg::S_INT: begin
                r_integ_new <= integ_sat;
                r_prod      <= mul_p;
            end
            pirc_pkg::S_ILO: begin
                r_acc  <= pirc_pkg::SUM_W'(r_target)
                        + pirc_pkg::SUM_W'($signed(r_prod[pirc_pkg::MUL_P_W-1:8]));
                r_prod <= mul_p;
            end
            pirc_pkg::S_IHI: begin
                // low partial product is nonnegative
                r_acc  <= r_acc + pirc_pkg::SUM_W'($signed(r_prod[pirc_pkg::MUL_P_W-1:24]));
                r_prod <= mul_p;
            end
            default: ;
        endcase
    end

    // integrator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
        end else if (r_state == pirc_pkg::S_FINISH && out_free) begin
            if (r_func_rst) begin
                r_integ <= '0;
            end else if (!((over_hi && r_err > 0) || (over_lo && r_err < 0))) begin
                r_integ <= r_integ_new;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == pirc_pkg::S_FINISH && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == pirc_pkg::S_FINISH && out_free) begin
            if (r_func_rst) begin
                r_drive   <= '0;
                r_clamped <= 1'b0;
            end else if (over_hi) begin
                r_drive   <= $signed({1'b0, r_max_output});
                r_clamped <= 1'b1;
            end else if (over_lo) begin
                r_drive   <= -$signed({1'b0, r_max_output});
                r_clamped <= 1'b1;
            end else begin
                r_drive   <= drive_sum[15:0];
                r_clamped <= 1'b0;
            end
        end
    end

    // a clamped result sits exactly on one of the limits
    a_clamp_on_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_clamped) |->
            (o_out_drive == $signed({1'b0, r_max_output}) ||
             o_out_drive == -$signed({1'b0, r_max_output})))
        else $error("clamped drive not on limit");

    // a reset item leaves the integrator cleared
    a_reset_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pirc_pkg::S_FINISH && out_free && r_func_rst) |=>
            (r_integ == '0 && o_out_valid && o_out_drive == '0))
        else $error("reset item did not clear integrator");

    // the sequencer never finishes over a result that was not transferred
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pirc_pkg::S_FINISH && r_out_valid && !i_out_ready) |=>
            (r_state == pirc_pkg::S_FINISH && $stable(r_drive)))
        else $error("result overwritten before transfer");

endmodule

`default_nettype wire

// File: tb/pi_rate_controller_feedforward_unit_tb.sv
`default_nettype none

module pi_rate_controller_feedforward_unit_tb;

    // cycles with no transfer on either side before the run is abandoned
    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic signed [15:0] drive;
        logic               clamped;
    } t_drive_result;

    // controller state mirror plus the queue of drive values still owed by the block
    class t_drive_scoreboard;
        logic [15:0]        p_gain;
        logic [15:0]        i_gain;
        logic [14:0]        max_out;
        logic [15:0]        slope;
        logic signed [47:0] integ;
        t_drive_result      drive_q[$];
        int                 errors;

        function new();
            p_gain  = 16'd0;
            i_gain  = 16'd0;
            max_out = 15'h7fff;
            slope   = 16'd256;
            integ   = '0;
            errors  = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                pirc_pkg::CFG_P_GAIN:     p_gain  = data;
                pirc_pkg::CFG_I_GAIN:     i_gain  = data;
                pirc_pkg::CFG_MAX_OUTPUT: max_out = data[14:0];
                pirc_pkg::CFG_SLOPE:      slope   = (data == 16'd0) ? 16'd1 : data;
                default: ;
            endcase
        endfunction

        // wide signed math, so every product and sum is exact before the clamp
        function void note_input(logic func, logic signed [15:0] target,
                                 logic signed [15:0] rate, logic [15:0] ticks);
            logic signed [95:0] tgt, rt, tk, sl, pg, ig, lim;
            logic signed [95:0] err, sum, next_integ, drv, imax, imin;
            t_drive_result      res;
            if (func == pirc_pkg::FUNC_RESET) begin
                integ = '0;
                res.drive   = '0;
                res.clamped = 1'b0;
                drive_q.push_back(res);
                return;
            end
            tgt  = 96'(target);
            rt   = 96'(rate);
            tk   = 96'(ticks);
            sl   = 96'(slope);
            pg   = 96'(p_gain);
            ig   = 96'(i_gain);
            lim  = 96'(max_out);
            imax = (96'sd1 <<< 47) - 96'sd1;
            imin = -imax - 96'sd1;
            err  = ((tgt * sl) >>> 8) - rt;
            sum  = integ + tk * err;
            if (sum > imax)
                next_integ = imax;
            else if (sum < imin)
                next_integ = imin;
            else
                next_integ = sum;
            drv = tgt + ((pg * err) >>> 8) + ((ig * next_integ) >>> 24);
            res.clamped = 1'b0;
            if (drv > lim) begin
                drv = lim;
                res.clamped = 1'b1;
                // clamp in the direction of the error: integrator keeps old value
                if (err > 0)
                    next_integ = 96'(integ);
            end else if (drv < -lim) begin
                drv = -lim;
                res.clamped = 1'b1;
                if (err < 0)
                    next_integ = 96'(integ);
            end
            integ     = next_integ[47:0];
            res.drive = drv[15:0];
            drive_q.push_back(res);
        endfunction

        task report(string what, logic [15:0] got, logic [15:0] want);
            $display("mismatch on %s: got %h, expected %h", what, got, want);
            errors++;
        endtask

        task check(logic signed [15:0] drive, logic clamped);
            t_drive_result want;
            if (drive_q.size() == 0) begin
                report("unexpected result", drive, 16'h0);
                return;
            end
            want = drive_q.pop_front();
            if (drive !== want.drive)
                report("drive", drive, want.drive);
            if (clamped !== want.clamped)
                report("clamped", {15'd0, clamped}, {15'd0, want.clamped});
        endtask

        function int pending();
            return drive_q.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n      = 1'b0;
    logic               cfg_we     = 1'b0;
    logic [1:0]         cfg_idx    = pirc_pkg::CFG_P_GAIN;
    logic [15:0]        cfg_data   = '0;
    logic               in_valid   = 1'b0;
    logic               in_ready;
    logic               in_func    = pirc_pkg::FUNC_SAMPLE;
    logic signed [15:0] in_target  = '0;
    logic signed [15:0] in_rate    = '0;
    logic [15:0]        in_ticks   = '0;
    logic               out_valid;
    logic               out_ready  = 1'b0;
    logic signed [15:0] out_drive;
    logic               out_clamped;

    // idle percentages, changed per phase by the stimulus
    int gap_pct   = 0;
    int stall_pct = 0;

    t_drive_scoreboard sb;

    pi_rate_controller_feedforward_unit dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_we            (cfg_we),
        .i_cfg_idx           (cfg_idx),
        .i_cfg_data          (cfg_data),
        .i_in_valid          (in_valid),
        .o_in_ready          (in_ready),
        .i_in_func           (in_func),
        .i_in_target_command (in_target),
        .i_in_measured_rate  (in_rate),
        .i_in_elapsed_ticks  (in_ticks),
        .o_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .o_out_drive         (out_drive),
        .o_out_clamped       (out_clamped)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // result side: check every transfer against the oldest expectation
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check(out_drive, out_clamped);
    end

    // result side back-pressure in random bursts
    initial begin
        forever begin
            @(posedge clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // watchdog: too long without any transfer ends the run
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // one item transfer; valid stays high into the next item when there is no gap
    task automatic send_item(input logic f, input logic signed [15:0] t,
                             input logic signed [15:0] r, input logic [15:0] k);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_func   <= f;
        in_target <= t;
        in_rate   <= r;
        in_ticks  <= k;
        do @(posedge clk); while (!in_ready);
        sb.note_input(f, t, r, k);
    endtask

    // hold off the sender until every owed result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // write all four registers back to back, only while the block is idle
    task automatic reconfigure(input logic [15:0] pg, input logic [15:0] ig,
                               input logic [15:0] mo, input logic [15:0] sl);
        logic [15:0] vals [4];
        logic [1:0]  idxs [4];
        vals = '{pg, ig, mo, sl};
        idxs = '{pirc_pkg::CFG_P_GAIN, pirc_pkg::CFG_I_GAIN,
                 pirc_pkg::CFG_MAX_OUTPUT, pirc_pkg::CFG_SLOPE};
        drain_results();
        for (int n = 0; n < 4; n++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= idxs[n];
            cfg_data <= vals[n];
            @(posedge clk);
            sb.write_reg(idxs[n], vals[n]);
        end
        cfg_we <= 1'b0;
    endtask

    // bias > 0 pushes the integrator up with large positive errors, bias < 0 down;
    // the remaining items are noise over the full field ranges
    task automatic send_samples(input int count, input int bias, input int reset_pct);
        logic               f;
        logic signed [15:0] t, r;
        logic [15:0]        k;
        for (int n = 0; n < count; n++) begin
            f = pirc_pkg::FUNC_SAMPLE;
            t = 16'($urandom);
            r = 16'($urandom);
            k = 16'($urandom);
            if (bias != 0 && $urandom_range(0, 99) < 95) begin
                k = 16'(16'hffff - $urandom_range(0, 255));
                if (bias > 0) begin
                    t = 16'(16'sh7fff - $urandom_range(0, 63));
                    r = 16'(16'sh8000 + $urandom_range(0, 63));
                end else begin
                    t = 16'(16'sh8001 + $urandom_range(0, 63));
                    r = 16'(16'sh7fff - $urandom_range(0, 63));
                end
            end else begin
                case ($urandom_range(0, 3))
                    0: k = 16'd0;
                    1: k = 16'($urandom_range(1, 15));
                    default: ;
                endcase
                if ($urandom_range(0, 7) == 0)
                    t = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                if ($urandom_range(0, 7) == 0)
                    r = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                if (bias == 0 && $urandom_range(0, 99) < reset_pct)
                    f = pirc_pkg::FUNC_RESET;
            end
            send_item(f, t, r, k);
            // occasional full drain in the middle of a phase
            if ($urandom_range(0, 49) == 0)
                drain_results();
        end
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults: drive follows the target
        gap_pct   = 20;
        stall_pct = 20;
        send_item(pirc_pkg::FUNC_SAMPLE, 16'sh0000, 16'sh0000, 16'h0000);
        send_item(pirc_pkg::FUNC_SAMPLE, 16'sh7fff, 16'sh8000, 16'hffff);
        // lower clamp while the error is negative: integrator held
        send_item(pirc_pkg::FUNC_SAMPLE, 16'sh8000, 16'sh7fff, 16'hffff);
        // reset item with junk in the other fields
        send_item(pirc_pkg::FUNC_RESET,  16'shffff, 16'shffff, 16'hffff);
        // zero ticks leaves the integrator alone
        send_item(pirc_pkg::FUNC_SAMPLE, 16'sd1234, -16'sd5,   16'h0000);

        // zero limit, zero slope write stored as one
        reconfigure(16'hffff, 16'hffff, 16'h0000, 16'h0000);
        send_item(pirc_pkg::FUNC_SAMPLE, 16'sh0000, 16'sh0000, 16'd100);
        send_item(pirc_pkg::FUNC_SAMPLE, 16'sd100,  16'sh0000, 16'h0000);
        send_item(pirc_pkg::FUNC_SAMPLE, -16'sd1,   16'sh0000, 16'h0001);
        send_item(pirc_pkg::FUNC_RESET,  16'sh0000, 16'sh0000, 16'h0000);

        // unity p gain, steep slope, full i gain
        reconfigure(16'd256, 16'hffff, 16'h7fff, 16'hffff);
        send_item(pirc_pkg::FUNC_SAMPLE, 16'sd16384, 16'sh0000, 16'h0001);
        send_item(pirc_pkg::FUNC_SAMPLE, 16'sh8000,  16'sh8000, 16'h0010);
        send_item(pirc_pkg::FUNC_SAMPLE, 16'sh0000,  16'sh7fff, 16'hffff);
        send_item(pirc_pkg::FUNC_SAMPLE, 16'sh0000,  16'sh8000, 16'hffff);
        send_item(pirc_pkg::FUNC_SAMPLE, 16'sd200,   -16'sd300, 16'h0003);
        send_item(pirc_pkg::FUNC_RESET,  16'sh7fff,  16'sh8000, 16'h0000);

        // no gains: integrator runs up to its positive saturation silently
        reconfigure(16'h0000, 16'h0000, 16'h7fff, 16'hffff);
        gap_pct   = 10;
        stall_pct = 10;
        send_samples(290, 1, 0);

        // saturated integrator seen through full gains and a zero limit
        reconfigure(16'hffff, 16'hffff, 16'h0000, 16'h0000);
        gap_pct   = 25;
        stall_pct = 25;
        send_samples(40, 0, 6);

        // max_output write with bit 15 set keeps only 15 bits
        reconfigure(16'd256, 16'd1, 16'hffff, 16'd256);
        gap_pct   = 30;
        stall_pct = 0;
        send_samples(40, 0, 6);

        // clear, then run down to negative saturation
        reconfigure(16'h0000, 16'h0000, 16'h7fff, 16'hffff);
        gap_pct   = 0;
        stall_pct = 10;
        send_item(pirc_pkg::FUNC_RESET, 16'sh0000, 16'sh0000, 16'h0000);
        send_samples(290, -1, 0);

        // random settings over the saturated negative integrator
        reconfigure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        gap_pct   = 20;
        stall_pct = 20;
        send_samples(40, 0, 6);

        // closing stretch with no idling on either side
        reconfigure(16'($urandom_range(0, 1024)), 16'($urandom_range(0, 255)),
                    16'($urandom), 16'($urandom_range(1, 512)));
        gap_pct   = 0;
        stall_pct = 0;
        send_samples(40, 0, 6);

        drain_results();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
